>>> hdl/rdwr_pkg.sv
// Shared types, widths and codes for the random draw without replacement block.
`default_nettype none
package rdwr_pkg;

    localparam int DRAWN_W        = 20;
    localparam int SIZE_W         = 21;
    localparam int RAND_W         = 31;
    localparam int SUM_W          = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int POOL_DEPTH_DEF = 1048576;
    localparam int POOL_SIZE_RST  = 1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'b1;

    localparam logic CMD_DRAW    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef logic [DRAWN_W-1:0] t_drawn;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [RAND_W-1:0]  t_rand;
    typedef logic [SUM_W-1:0]   t_sum;

endpackage
`default_nettype wire

>>> hdl/rdwr_req_if.sv
// Request channel: command and random value with valid/ready handshake.
`default_nettype none
interface rdwr_req_if
    import rdwr_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  cmd;
    t_rand random_value;

    modport source (output valid, output cmd, output random_value, input ready);
    modport sink   (input valid, input cmd, input random_value, output ready);
endinterface
`default_nettype wire

>>> hdl/rdwr_res_if.sv
// Result channel: drawn entry and empty flag with valid/ready handshake.
`default_nettype none
interface rdwr_res_if
    import rdwr_pkg::*;
;
    logic   valid;
    logic   ready;
    t_drawn drawn_value;
    logic   empty_res;

    modport source (output valid, output drawn_value, output empty_res, input ready);
    modport sink   (input valid, input drawn_value, input empty_res, output ready);
endinterface
`default_nettype wire

>>> hdl/rdwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rdwr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hdl/rdwr_mod.sv
// Bit-serial restoring modulo unit: one dividend bit per cycle, MSB first.
`default_nettype none
module rdwr_mod
    import rdwr_pkg::*;
#(
    parameter int CW = 21
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_sum          i_dividend,
    input  wire logic [CW-1:0] i_divisor,
    output logic               o_done,
    output logic      [CW-1:0] o_rem
);
    localparam int NW = $clog2(SUM_W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_cnt, n_cnt;
    t_sum          r_dvd, n_dvd;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW:0]   w_trial;
    logic [CW:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_dvd[SUM_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(SUM_W);
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // keep the partial remainder below the divisor
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = w_diff[CW-1:0];
            end else begin
                n_rem = w_trial[CW-1:0];
            end
            n_dvd = {r_dvd[SUM_W-2:0], 1'b0};
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> hdl/random_draw_without_replacement_core.sv
// Top level: pool of entries drawn at random without replacement.
// Usage
//   Requests arrive on i_req (valid/ready). cmd = draw takes one entry from
//   the pool at position (offset + random_value) mod remaining, swaps it to
//   the last live slot and shrinks the live count; cmd = restart reloads the
//   live count from pool_size. Every request gives exactly one result on
//   o_res: the drawn entry and the empty flag.
//   Configuration (pool_size, loop_mode) must be written through i_cfg_we,
//   i_cfg_idx and i_cfg_data only while no request is in flight; not enforced.
// Sequence
//   A draw runs through the bit-serial modulo unit (32 dividend bits, one a
//   cycle, then the remainder handover), then the reads and swap writes on
//   the pool RAM (S_RDA, S_RDB, S_WRA, S_WRB), then S_DONE loads the output
//   register. Restart and empty-pool draws go straight to S_DONE to load
//   theirs. One request is in work at a time.
// Reset and stall
//   After reset the pool RAM is filled with the identity permutation, one
//   entry per cycle, and requests are held off until that pass ends;
//   configuration writes are taken during that pass. The result waits in
//   an output register while o_res.ready is low; the next request may be
//   accepted meanwhile and holds in its last step until the register frees.
`default_nettype none
module random_draw_without_replacement_core
    import rdwr_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rdwr_req_if.sink                  i_req,
    rdwr_res_if.source                o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire t_size                i_cfg_data
);
    localparam int AW      = $clog2(POOL_DEPTH);
    localparam int CW      = $clog2(POOL_DEPTH + 1);
    localparam int EFF_RST = (POOL_SIZE_RST > POOL_DEPTH) ? POOL_DEPTH :
                             ((POOL_SIZE_RST < 1) ? 1 : POOL_SIZE_RST);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RDA   = 3'd3;
    localparam logic [2:0] S_RDB   = 3'd4;
    localparam logic [2:0] S_WRA   = 3'd5;
    localparam logic [2:0] S_WRB   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    t_size         r_pool_size;
    logic          r_loop_mode;
    logic [CW-1:0] r_remaining, n_remaining;
    logic [AW-1:0] r_off_stop, n_off_stop;
    logic [AW-1:0] r_off_loop, n_off_loop;
    logic [AW-1:0] r_pos, n_pos;
    t_drawn        r_got, n_got;
    t_drawn        r_res_drawn, n_res_drawn;
    logic          r_res_empty, n_res_empty;
    logic          r_out_valid, n_out_valid;
    t_drawn        r_out_drawn, n_out_drawn;
    logic          r_out_empty, n_out_empty;

    logic [SUM_W-1:0] w_size_ext;
    logic [CW-1:0]    w_eff;
    logic [CW-1:0]    w_last_cnt;
    logic [AW-1:0]    w_last;
    logic             w_div_start;
    t_sum             w_sum;
    logic             w_div_done;
    logic [CW-1:0]    w_div_rem;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_drawn           w_wdata;
    logic [AW-1:0]    w_raddr;
    t_drawn           w_rdata;
    logic             w_out_free;

    // clamp pool_size into 1..POOL_DEPTH whenever it loads the live count
    always_comb begin
        w_size_ext = SUM_W'(r_pool_size);
        if (w_size_ext == '0) begin
            w_eff = CW'(1);
        end else if (w_size_ext > SUM_W'(POOL_DEPTH)) begin
            w_eff = CW'(POOL_DEPTH);
        end else begin
            w_eff = w_size_ext[CW-1:0];
        end
    end

    assign w_last_cnt = r_remaining - CW'(1);
    assign w_last     = w_last_cnt[AW-1:0];
    assign w_out_free = !r_out_valid || o_res.ready;

    rdwr_mod #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum),
        .i_divisor  (r_remaining),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    rdwr_ram #(
        .WIDTH (DRAWN_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_remaining = r_remaining;
        n_off_stop  = r_off_stop;
        n_off_loop  = r_off_loop;
        n_pos       = r_pos;
        n_got       = r_got;
        n_res_drawn = r_res_drawn;
        n_res_empty = r_res_empty;
        n_out_valid = r_out_valid;
        n_out_drawn = r_out_drawn;
        n_out_empty = r_out_empty;
        w_div_start = 1'b0;
        w_sum       = r_loop_mode ? (SUM_W'(r_off_loop) + SUM_W'(i_req.random_value))
                                  : (SUM_W'(r_off_stop) + SUM_W'(i_req.random_value));
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = w_rdata;
        w_raddr     = r_pos;

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // write the identity permutation, one entry a cycle
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = DRAWN_W'(r_clr_addr);
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(POOL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_drawn = '0;
                    n_res_empty = 1'b0;
                    if (i_req.cmd == CMD_RESTART) begin
                        n_remaining = w_eff;
                        n_state     = S_DONE;
                    end else if (!r_loop_mode && r_remaining == '0) begin
                        n_res_empty = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        // loop mode after a drained stop run: reload first
                        if (r_remaining == '0) begin
                            n_remaining = w_eff;
                        end
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pos = w_div_rem[AW-1:0];
                    if (r_loop_mode) begin
                        n_off_loop = w_div_rem[AW-1:0];
                    end else begin
                        n_off_stop = w_div_rem[AW-1:0];
                    end
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                w_raddr = r_pos;
                n_state = S_RDB;
            end
            S_RDB: begin
                // pool[pos] arrives now; fetch the last live slot next
                w_raddr = w_last;
                n_got   = w_rdata;
                n_state = S_WRA;
            end
            S_WRA: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = w_rdata;
                n_state = S_WRB;
            end
            S_WRB: begin
                w_we        = 1'b1;
                w_waddr     = w_last;
                w_wdata     = r_got;
                n_res_drawn = r_got;
                n_remaining = w_last_cnt;
                if (r_loop_mode && w_last_cnt == '0) begin
                    n_remaining = w_eff;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_drawn = r_res_drawn;
                    n_out_empty = r_res_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pool_size <= SIZE_W'(POOL_SIZE_RST);
            r_loop_mode <= 1'b0;
            r_remaining <= CW'(EFF_RST);
            r_off_stop  <= '0;
            r_off_loop  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_remaining <= n_remaining;
            r_off_stop  <= n_off_stop;
            r_off_loop  <= n_off_loop;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POOL_SIZE: r_pool_size <= i_cfg_data;
                    CFG_LOOP_MODE: r_loop_mode <= i_cfg_data[0];
                    default: begin
                        r_loop_mode <= r_loop_mode;
                    end
                endcase
            end
        end
        r_pos       <= n_pos;
        r_got       <= n_got;
        r_res_drawn <= n_res_drawn;
        r_res_empty <= n_res_empty;
        r_out_drawn <= n_out_drawn;
        r_out_empty <= n_out_empty;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.drawn_value = r_out_drawn;
    assign o_res.empty_res   = r_out_empty;
endmodule
`default_nettype wire
